/* rtl/core/hglp_pkg.sv */
// ---------------------------------------------------------------------------
// hglp_pkg
// Shared types, character codes and status codes for the request line parser.
// ---------------------------------------------------------------------------
package hglp_pkg;

  localparam int unsigned CfgWidth = 16;

  localparam logic [CfgWidth-1:0] REQ_LEN_RESET  = 16'd1000;
  localparam logic [CfgWidth-1:0] NAME_LEN_RESET = 16'd256;

  localparam logic CFG_MAX_REQUEST_LEN = 1'b0;
  localparam logic CFG_MAX_NAME_LEN    = 1'b1;

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOTERM  = 3'd1;
  localparam logic [2:0] ST_METHOD  = 3'd2;
  localparam logic [2:0] ST_SYNTAX  = 3'd3;
  localparam logic [2:0] ST_TOOLONG = 3'd4;

  localparam logic KIND_NAME   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] name_byte;
    logic [2:0] status;
    logic       name_empty;
    logic       last;
  } res_t;

  typedef struct packed {
    logic valid;
    req_t data;
  } req_beat_t;

  typedef struct packed {
    logic valid;
    res_t data;
  } res_beat_t;

  function automatic logic [7:0] method_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;  // G
      2'd1:    c = 8'h45;  // E
      2'd2:    c = 8'h54;  // T
      default: c = CH_SP;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;  // H
      3'd1:    c = 8'h54;  // T
      3'd2:    c = 8'h54;  // T
      3'd3:    c = 8'h50;  // P
      3'd4:    c = 8'h2F;  // /
      3'd5:    c = 8'h31;  // 1
      3'd6:    c = 8'h2E;  // .
      default: c = 8'h31;  // 1
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/hglp_stream_if.sv */
// ---------------------------------------------------------------------------
// hglp_stream_if
// Valid/ready channel carrying one payload beat.
// ---------------------------------------------------------------------------
interface hglp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/hglp_in_stage.sv */
// ---------------------------------------------------------------------------
// hglp_in_stage
// Input register: captures request beats, refills in the cycle it drains.
// ---------------------------------------------------------------------------
module hglp_in_stage
  import hglp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  hglp_stream_if.sink   request,
  input  logic          advance,
  output req_beat_t     beat
);

  logic valid;
  req_t data;

  assign request.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (request.ready) begin
      valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.ready && request.valid) begin
      data <= request.data;
    end
  end

  assign beat.valid = valid;
  assign beat.data  = data;

endmodule

/* rtl/core/hglp_step.sv */
// ---------------------------------------------------------------------------
// hglp_step
// Parser state, configuration registers and the per-byte update logic.
// ---------------------------------------------------------------------------
module hglp_step
  import hglp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CfgWidth-1:0] cfg_data,
  input  req_beat_t           beat,
  input  logic                advance,
  output res_beat_t           res
);

  typedef enum logic [6:0] {
    PH_METHOD  = 7'b0000001,
    PH_SKIP    = 7'b0000010,
    PH_TARGET  = 7'b0000100,
    PH_VERSION = 7'b0001000,
    PH_HEADER  = 7'b0010000,
    PH_FAILED  = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  logic [CfgWidth-1:0] max_request_len;
  logic [CfgWidth-1:0] max_name_len;

  phase_t      phase, phase_next;
  logic [3:0]  match_index, match_index_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] name_length, name_length_next;
  logic [2:0]  error_code, error_code_next;
  logic [1:0]  term, term_next;

  logic [7:0]  b;
  logic        at_end;
  logic        crlf;
  logic        complete;
  logic        emit_name;
  logic        fail;
  logic [2:0]  fail_code;
  logic [15:0] name_limit;
  logic [15:0] req_limit;
  logic        finish;
  logic [2:0]  st;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_request_len <= REQ_LEN_RESET;
      max_name_len    <= NAME_LEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MAX_REQUEST_LEN: max_request_len <= cfg_data;
        CFG_MAX_NAME_LEN:    max_name_len    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign b      = beat.data.data_byte;
  assign at_end = beat.data.buffer_end;
  assign crlf   = (b == CH_CR) || (b == CH_LF);

  assign name_limit = (max_name_len != '0) ? max_name_len - 16'd1 : '0;
  assign req_limit  = (max_request_len != '0) ? max_request_len - 16'd1 : '0;

  always_comb begin
    phase_next       = phase;
    match_index_next = match_index;
    byte_count_next  = byte_count;
    name_length_next = name_length;
    error_code_next  = error_code;
    term_next        = term;
    complete         = 1'b0;
    emit_name        = 1'b0;
    fail             = 1'b0;
    fail_code        = ST_OK;
    finish           = 1'b0;
    st               = ST_OK;
    res.valid        = 1'b0;
    res.data         = '0;

    if (phase != PH_DONE) begin
      if (byte_count != 16'hFFFF) begin
        byte_count_next = byte_count + 16'd1;
      end

      if (b == CH_CR) begin
        term_next = (term == 2'd2) ? 2'd3 : 2'd1;
      end else if (b == CH_LF) begin
        complete  = (term == 2'd3);
        term_next = (term == 2'd1) ? 2'd2 : 2'd0;
      end else begin
        term_next = 2'd0;
      end

      unique case (phase)
        PH_METHOD: begin
          if (!match_index[3] && !match_index[2] && b == method_char(match_index[1:0])) begin
            if (match_index == 4'd3) begin
              match_index_next = '0;
              phase_next       = PH_SKIP;
            end else begin
              match_index_next = match_index + 4'd1;
            end
          end else begin
            fail      = 1'b1;
            fail_code = crlf ? ST_SYNTAX : ST_METHOD;
          end
        end
        PH_SKIP: begin
          if (b == CH_SP || crlf) begin
            fail      = 1'b1;
            fail_code = ST_SYNTAX;
          end else begin
            phase_next = PH_TARGET;
          end
        end
        PH_TARGET: begin
          if (crlf) begin
            fail      = 1'b1;
            fail_code = ST_SYNTAX;
          end else if (b == CH_SP) begin
            match_index_next = '0;
            phase_next       = PH_VERSION;
          end else if (name_length < name_limit) begin
            name_length_next = name_length + 16'd1;
            emit_name        = 1'b1;
          end else begin
            fail      = 1'b1;
            fail_code = ST_TOOLONG;
          end
        end
        PH_VERSION: begin
          if (!match_index[3]) begin
            if (b == version_char(match_index[2:0])) begin
              match_index_next = match_index + 4'd1;
            end else begin
              fail      = 1'b1;
              fail_code = ST_SYNTAX;
            end
          end else if (b == CH_CR) begin
            phase_next = PH_HEADER;
          end else begin
            fail      = 1'b1;
            fail_code = ST_SYNTAX;
          end
        end
        PH_HEADER, PH_FAILED, PH_DONE: ;
        default: ;
      endcase

      if (fail) begin
        if (fail_code == ST_TOOLONG) begin
          if (error_code == ST_OK) begin
            error_code_next = ST_TOOLONG;
          end
        end else begin
          if (error_code == ST_OK || error_code == ST_TOOLONG) begin
            error_code_next = fail_code;
          end
          phase_next = PH_FAILED;
        end
      end

      finish = complete || at_end || (byte_count_next >= req_limit);

      if (finish) begin
        if (complete && byte_count_next <= req_limit) begin
          st = (phase_next != PH_HEADER && error_code_next == ST_OK) ? ST_SYNTAX
                                                                      : error_code_next;
        end else begin
          st = ST_NOTERM;
        end
        res.valid            = 1'b1;
        res.data.result_kind = KIND_STATUS;
        res.data.status      = st;
        res.data.name_empty  = (st == ST_OK) && (name_length_next == '0);
        res.data.last        = 1'b1;
        phase_next           = PH_DONE;
      end else if (emit_name) begin
        res.valid            = 1'b1;
        res.data.result_kind = KIND_NAME;
        res.data.name_byte   = b;
      end
    end

    // restart on the closing byte of the client buffer
    if ((phase == PH_DONE || finish) && at_end) begin
      phase_next       = PH_METHOD;
      match_index_next = '0;
      byte_count_next  = '0;
      name_length_next = '0;
      error_code_next  = ST_OK;
      term_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_METHOD;
      match_index <= '0;
      byte_count  <= '0;
      name_length <= '0;
      error_code  <= ST_OK;
      term        <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      match_index <= match_index_next;
      byte_count  <= byte_count_next;
      name_length <= name_length_next;
      error_code  <= error_code_next;
      term        <= term_next;
    end
  end

endmodule

/* rtl/core/hglp_out_stage.sv */
// ---------------------------------------------------------------------------
// hglp_out_stage
// Result register: holds a beat until the receiver takes it.
// ---------------------------------------------------------------------------
module hglp_out_stage
  import hglp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           beat_valid,
  input  res_beat_t      res,
  output logic           advance,
  hglp_stream_if.source  result
);

  logic valid;
  res_t data;

  assign advance = beat_valid && (!valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= res.valid;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      data <= res.data;
    end
  end

  assign result.valid = valid;
  assign result.data  = data;

endmodule

/* rtl/core/http_get_request_line_parser_top.sv */
// ---------------------------------------------------------------------------
// http_get_request_line_parser_top
// Streaming parser for the request line of a GET request.
//
// request carries one byte per beat with a buffer_end flag on the last byte
// of the client buffer. result carries either a name byte (result_kind 0)
// or one closing status beat per request (result_kind 1, last 1). A status
// of ok with name_empty set means the default file applies.
// Throughput is one byte per cycle while result is not stalled. A request
// beat goes into the input register, then into the result register.
// Bytes that produce nothing still take one slot in the input register.
// When result is stalled the result register holds and the input register
// stops draining; request stays ready while the input register is empty.
// Reset clears both registers, returns the parser to the method check, loads
// max_request_len 1000, max_name_len 256. Configuration writes take effect on
// the next edge; the user makes them while the block is idle (not enforced).
// ---------------------------------------------------------------------------
module http_get_request_line_parser_top
  import hglp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CfgWidth-1:0] cfg_data,
  hglp_stream_if.sink         request,
  hglp_stream_if.source       result
);

  req_beat_t beat;
  res_beat_t res;
  logic      advance;

  hglp_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .advance (advance),
    .beat    (beat)
  );

  hglp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .beat      (beat),
    .advance   (advance),
    .res       (res)
  );

  hglp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat.valid),
    .res        (res),
    .advance    (advance),
    .result     (result)
  );

  a_stall_holds_parser: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !advance)
    else $error("parser advanced while result stalled");

  a_name_beat_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.result_kind == KIND_NAME |->
      !result.data.last && result.data.status == ST_OK && !result.data.name_empty)
    else $error("name beat carries status fields");

  a_empty_only_ok: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.name_empty |->
      result.data.status == ST_OK && result.data.result_kind == KIND_STATUS)
    else $error("name_empty on a non-ok beat");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.status <= ST_TOOLONG)
    else $error("status code out of range");

endmodule
